@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the divider search RTL.
// Needs nothing else; include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PDS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define PDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/pds_pkg.sv @@
// Package for the PLL divider search: constants, state enum, command,
// status and result structs. No dependencies.
package pds_pkg;

   localparam int FREQ_W = 24;
   localparam int REF_W  = 23;
   localparam int DIV_W  = 6;
   localparam int P_W    = 2;
   localparam int NUM_W  = 32;
   localparam int DEN_W  = 5;
   localparam int MFAC_W = 7;
   localparam int CNT_W  = 5;

   localparam logic [DIV_W-1:0] M_FIRST  = 6'd1;
   localparam logic [DIV_W-1:0] M_LAST   = 6'd62;
   localparam logic [DIV_W-1:0] N_FIRST  = 6'd40;
   localparam logic [DIV_W-1:0] N_LAST   = 6'd62;
   localparam logic [DIV_W:0]   DIV_BASE = 7'd65;
   localparam logic [P_W-1:0]   P_LAST   = 2'd3;
   localparam logic [CNT_W-1:0] CNT_LAST = 5'd31;

   localparam logic [REF_W-1:0]  REF_FREQ_RST = 23'd938357;
   localparam logic [FREQ_W-1:0] VCO_MIN_RST  = 24'd7208960;
   localparam logic [FREQ_W-1:0] VCO_MAX_RST  = 24'd14417920;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] CSR_REF_FREQ = 2'd0;
   localparam logic [1:0] CSR_VCO_MIN  = 2'd1;
   localparam logic [1:0] CSR_VCO_MAX  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_CHECK,
      ST_PEVAL,
      ST_NEXT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic init;
      logic load;
      logic step;
      logic eval;
      logic advance;
      logic done;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic in_range;
      logic p_last;
      logic pair_last;
   } status_type;

   typedef struct packed {
      logic [FREQ_W-1:0] achieved_freq;
      logic [DIV_W-1:0]  m_value;
      logic [DIV_W-1:0]  n_value;
      logic [P_W-1:0]    p_value;
      logic              found;
   } result_type;

endpackage

@@ hw/rtl/pds_ctrl.sv @@
// Sequencer for the divider search: walks (m, n) pairs, the serial
// divide, the range check and the four p evaluations. Uses pds_pkg.
module pds_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                out_free,
   input  pds_pkg::status_type status,
   output pds_pkg::cmd_type    cmd
);
   import pds_pkg::*;

   `include "assert_macros.svh"

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.init = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.in_range ? ST_PEVAL : ST_NEXT;
         end
         ST_PEVAL: begin
            cmd.eval = 1'b1;
            if (status.p_last) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (status.pair_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `PDS_ASSERT_SAME(a_done_needs_slot, clock, reset, cmd.done, out_free, "result dropped")
   `PDS_ASSERT_NEXT(a_div_to_check, clock, reset, state_ff == ST_DIV && status.div_last,
                    state_ff == ST_CHECK, "divide did not end in range check")

endmodule

@@ hw/rtl/pds_datapath.sv @@
// Datapath for the divider search: loop counters, numerator multiply,
// restoring serial divider and best-candidate tracking. Uses pds_pkg.
module pds_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  pds_pkg::cmd_type                  cmd,
   input  logic [pds_pkg::FREQ_W-1:0]        target_freq,
   input  logic [pds_pkg::REF_W-1:0]         ref_freq,
   input  logic [pds_pkg::FREQ_W-1:0]        vco_min,
   input  logic [pds_pkg::FREQ_W-1:0]        vco_max,
   output pds_pkg::status_type               status,
   output pds_pkg::result_type               result
);
   import pds_pkg::*;

   logic [DIV_W-1:0]  m_ff, m_in, n_ff, n_in;
   logic [P_W-1:0]    p_ff, p_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  acc_ff, acc_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [FREQ_W-1:0] target_ff, target_in;
   logic [FREQ_W-1:0] best_err_ff, best_err_in;
   result_type        best_ff, best_in;

   logic [MFAC_W-1:0] mfac;
   logic [DEN_W-1:0]  dfac;
   logic [28:0]       prod;
   logic [DEN_W:0]    trial;
   logic              ge;
   logic [FREQ_W-1:0] cand_f;
   logic [FREQ_W-1:0] cand_err;

   assign mfac  = DIV_BASE - {1'b0, m_ff};
   assign dfac  = DEN_W'(DIV_BASE - {1'b0, n_ff});
   assign prod  = 29'(ref_freq) * 29'(mfac);
   assign trial = {rem_ff, acc_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, dfac};

   assign cand_f   = acc_ff[FREQ_W-1:0] >> p_ff;
   assign cand_err = (target_ff >= cand_f) ? (target_ff - cand_f) : (cand_f - target_ff);

   always_comb begin
      m_in        = m_ff;
      n_in        = n_ff;
      p_in        = p_ff;
      cnt_in      = cnt_ff;
      acc_in      = acc_ff;
      rem_in      = rem_ff;
      target_in   = target_ff;
      best_err_in = best_err_ff;
      best_in     = best_ff;
      if (cmd.init) begin
         m_in      = M_FIRST;
         n_in      = N_FIRST;
         target_in = target_freq;
         best_in   = '0;
      end
      if (cmd.load) begin
         acc_in = {prod, 3'b000};
         rem_in = '0;
         cnt_in = '0;
         p_in   = '0;
      end
      if (cmd.step) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, dfac}) : trial[DEN_W-1:0];
         acc_in = {acc_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.eval) begin
         p_in = p_ff + 1'b1;
         if (!best_ff.found || cand_err <= best_err_ff) begin
            best_err_in           = cand_err;
            best_in.achieved_freq = cand_f;
            best_in.m_value       = m_ff;
            best_in.n_value       = n_ff;
            best_in.p_value       = p_ff;
            best_in.found         = 1'b1;
         end
      end
      if (cmd.advance) begin
         if (n_ff == N_LAST) begin
            n_in = N_FIRST;
            m_in = m_ff + 1'b1;
         end else begin
            n_in = n_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      n_ff        <= n_in;
      p_ff        <= p_in;
      cnt_ff      <= cnt_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      target_ff   <= target_in;
      best_err_ff <= best_err_in;
   end

   assign status.div_last  = cnt_ff == CNT_LAST;
   assign status.in_range  = (acc_ff >= NUM_W'(vco_min)) && (acc_ff < NUM_W'(vco_max));
   assign status.p_last    = p_ff == P_LAST;
   assign status.pair_last = (m_ff == M_LAST) && (n_ff == N_LAST);
   assign result           = best_ff;

endmodule

@@ hw/rtl/pll_divider_search_core.sv @@
// Top level of the PLL divider search: CSR block, output register and the
// controller/datapath pair. Uses pds_pkg, pds_ctrl, pds_datapath.
//
// One request at a time. Each request sweeps all 1426 (m, n) pairs; a pair
// takes a load, a 32-step serial divide, a range check and an advance, plus
// four p evaluations when its VCO is in range. The serial divider sets the
// pace. When the sweep ends the controller waits in its done state until
// the output register is free, moves the result into it and returns to
// idle, where the next request is accepted.
// CSRs: 0x0 ref_freq, 0x4 vco_min, 0x8 vco_max; write them only while no
// request is in flight.
module pll_divider_search_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pds_pkg::FREQ_W-1:0]           req_target_freq,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pds_pkg::FREQ_W-1:0]           rsp_achieved_freq,
   output logic [pds_pkg::DIV_W-1:0]            rsp_m_value,
   output logic [pds_pkg::DIV_W-1:0]            rsp_n_value,
   output logic [pds_pkg::P_W-1:0]              rsp_p_value,
   output logic                                 rsp_found,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [pds_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [pds_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [pds_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import pds_pkg::*;

   `include "assert_macros.svh"

   logic [REF_W-1:0]  ref_freq_ff;
   logic [FREQ_W-1:0] vco_min_ff, vco_max_ff;
   logic              csr_wr;
   logic [1:0]        csr_idx;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;
   logic              out_free;

   cmd_type           cmd;
   status_type        status;
   result_type        result;

   assign pready  = 1'b1;
   assign csr_idx = paddr[3:2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_freq_ff <= REF_FREQ_RST;
         vco_min_ff  <= VCO_MIN_RST;
         vco_max_ff  <= VCO_MAX_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_REF_FREQ: ref_freq_ff <= pwdata[REF_W-1:0];
            CSR_VCO_MIN:  vco_min_ff  <= pwdata[FREQ_W-1:0];
            CSR_VCO_MAX:  vco_max_ff  <= pwdata[FREQ_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_REF_FREQ: prdata = CSR_DATA_W'(ref_freq_ff);
         CSR_VCO_MIN:  prdata = CSR_DATA_W'(vco_min_ff);
         CSR_VCO_MAX:  prdata = CSR_DATA_W'(vco_max_ff);
         default:      prdata = '0;
      endcase
   end

   pds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd)
   );

   pds_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .target_freq (req_target_freq),
      .ref_freq    (ref_freq_ff),
      .vco_min     (vco_min_ff),
      .vco_max     (vco_max_ff),
      .status      (status),
      .result      (result)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_achieved_freq = rsp_ff.achieved_freq;
   assign rsp_m_value       = rsp_ff.m_value;
   assign rsp_n_value       = rsp_ff.n_value;
   assign rsp_p_value       = rsp_ff.p_value;
   assign rsp_found         = rsp_ff.found;

   `PDS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready,
                    "request accepted while search running")
   `PDS_ASSERT_SAME(a_not_found_zero, clock, reset, rsp_valid && !rsp_found,
                    rsp_achieved_freq == '0 && rsp_m_value == '0 && rsp_n_value == '0,
                    "empty result carries nonzero fields")

endmodule
